// ===== hdl/bfrmm_pkg.sv =====
// shared constants, types and register codes for the boxcar filter with rms and peak tracking
// no dependencies
package bfrmm_pkg;

    localparam int TAPS         = 10;
    localparam int STATS_WINDOW = 10;
    localparam int SAMPLE_BITS  = 10;

    localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
    localparam int FULL_SCALE = TAPS * SAMPLE_MAX;
    localparam int VALUE_W    = 14;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 1;

    localparam int WIN_IDX_W = $clog2(STATS_WINDOW);
    localparam int STEP_W    = $clog2(STATS_WINDOW + 1);

    localparam longint SQ_MAX = longint'(STATS_WINDOW) * FULL_SCALE * FULL_SCALE;
    localparam int     SQ_W   = $clog2(SQ_MAX + 1);

    // mean of squares by reciprocal multiply
    localparam int     RECIP_SHIFT = SQ_W + $clog2(STATS_WINDOW);
    localparam longint RECIP       = ((longint'(1) << RECIP_SHIFT) + STATS_WINDOW - 1)
                                     / STATS_WINDOW;
    localparam int     RECIP_W     = $clog2(RECIP + 1);
    localparam int     MUL_W       = SQ_W + RECIP_W;

    localparam int MEAN_W     = $clog2(SQ_MAX / STATS_WINDOW + 1);
    localparam int ROOT_STEPS = (MEAN_W + 1) / 2;
    localparam int SQ_BIT_W   = 2 * ROOT_STEPS;
    localparam int SQ_TOP     = SQ_BIT_W - 2;

    localparam logic [CFG_IDX_W-1:0] CFG_STATS_INTERVAL   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLISH_INTERVAL = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] STATS_INTERVAL_RST   = CFG_W'(10);
    localparam logic [CFG_W-1:0] PUBLISH_INTERVAL_RST = CFG_W'(50);

    typedef struct packed {
        logic                 shift;
        logic [WIN_IDX_W-1:0] rd_idx;
    } win_ctrl_t;

    typedef struct packed {
        logic               stats;
        logic               publish;
        logic [VALUE_W-1:0] rms;
        logic [VALUE_W-1:0] held_high;
        logic [VALUE_W-1:0] held_low;
    } stats_res_t;

endpackage

// ===== hdl/bfrmm_window.sv =====
// raw sample delay line with running boxcar sum, and delay line of filtered values
// depends on bfrmm_pkg
module bfrmm_window (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bfrmm_pkg::win_ctrl_t                  ctrl,
    input  logic [bfrmm_pkg::SAMPLE_BITS-1:0]     sample,
    output logic [bfrmm_pkg::VALUE_W-1:0]         sum,
    output logic [bfrmm_pkg::VALUE_W-1:0]         rd_data
);
    import bfrmm_pkg::*;

    logic [SAMPLE_BITS-1:0] raw_reg  [TAPS];
    logic [VALUE_W-1:0]     filt_reg [STATS_WINDOW];
    logic [VALUE_W-1:0]     sum_reg;
    logic [VALUE_W-1:0]     sum_next;

    assign sum_next = sum_reg + VALUE_W'(sample) - VALUE_W'(raw_reg[TAPS-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            for (int i = 0; i < TAPS; i++)
            begin
                raw_reg[i] <= '0;
            end
            for (int i = 0; i < STATS_WINDOW; i++)
            begin
                filt_reg[i] <= '0;
            end
        end
        else if (ctrl.shift)
        begin
            sum_reg    <= sum_next;
            raw_reg[0] <= sample;
            for (int i = 1; i < TAPS; i++)
            begin
                raw_reg[i] <= raw_reg[i-1];
            end
            filt_reg[0] <= sum_next;
            for (int i = 1; i < STATS_WINDOW; i++)
            begin
                filt_reg[i] <= filt_reg[i-1];
            end
        end
    end

    assign sum     = sum_reg;
    assign rd_data = (int'(ctrl.rd_idx) < STATS_WINDOW) ? filt_reg[ctrl.rd_idx] : '0;

endmodule

// ===== hdl/bfrmm_stats.sv =====
// sequencer with shared multiplier and square root step: window walk, mean, rms, extremes
// depends on bfrmm_pkg
module bfrmm_stats (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 take,
    input  logic [bfrmm_pkg::CFG_W-1:0]          stats_interval,
    input  logic [bfrmm_pkg::CFG_W-1:0]          publish_interval,
    input  logic [bfrmm_pkg::VALUE_W-1:0]        rd_data,
    output logic [bfrmm_pkg::WIN_IDX_W-1:0]      rd_idx,
    output logic                                 idle,
    output logic                                 done,
    output bfrmm_pkg::stats_res_t                res
);
    import bfrmm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_RECIP = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_SQRT  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CFG_W-1:0]    sample_cnt_reg, sample_cnt_next;
    logic [CFG_W-1:0]    window_cnt_reg, window_cnt_next;
    logic                stats_reg, stats_next;
    logic                publish_reg, publish_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SQ_W-1:0]     acc_reg, acc_next;
    logic [MUL_W-1:0]    prod_reg, prod_next;
    logic [VALUE_W-1:0]  run_hi_reg, run_hi_next;
    logic [VALUE_W-1:0]  run_lo_reg, run_lo_next;
    logic [VALUE_W-1:0]  held_hi_reg, held_hi_next;
    logic [VALUE_W-1:0]  held_lo_reg, held_lo_next;
    logic [VALUE_W-1:0]  rms_reg, rms_next;
    logic [SQ_BIT_W-1:0] rem_reg, rem_next;
    logic [SQ_BIT_W-1:0] root_reg, root_next;
    logic [SQ_BIT_W-1:0] bit_reg, bit_next;

    logic [SQ_W-1:0]     mul_a;
    logic [RECIP_W-1:0]  mul_b;
    logic [MUL_W-1:0]    mul_out;
    logic [SQ_BIT_W:0]   trial;
    logic                trial_ok;
    logic [CFG_W-1:0]    sample_inc;
    logic [CFG_W-1:0]    window_inc;

    // shared multiplier: squares during the walk, reciprocal for the mean
    always_comb
    begin
        if (state_reg == ST_RECIP)
        begin
            mul_a = acc_reg;
            mul_b = RECIP_W'(RECIP);
        end
        else
        begin
            mul_a = SQ_W'(rd_data);
            mul_b = RECIP_W'(rd_data);
        end
    end

    assign mul_out    = MUL_W'(mul_a) * MUL_W'(mul_b);
    assign trial      = {1'b0, root_reg} + {1'b0, bit_reg};
    assign trial_ok   = {1'b0, rem_reg} >= trial;
    assign sample_inc = sample_cnt_reg + 1'b1;
    assign window_inc = window_cnt_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        sample_cnt_next = sample_cnt_reg;
        window_cnt_next = window_cnt_reg;
        stats_next      = stats_reg;
        publish_next    = publish_reg;
        step_next       = step_reg;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        run_hi_next     = run_hi_reg;
        run_lo_next     = run_lo_reg;
        held_hi_next    = held_hi_reg;
        held_lo_next    = held_lo_reg;
        rms_next        = rms_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        bit_next        = bit_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    step_next = '0;
                    acc_next  = '0;
                    prod_next = '0;
                    if (sample_inc == stats_interval)
                    begin
                        sample_cnt_next = '0;
                        stats_next      = 1'b1;
                        state_next      = ST_WALK;
                        if (window_inc == publish_interval)
                        begin
                            window_cnt_next = '0;
                            publish_next    = 1'b1;
                        end
                        else
                        begin
                            window_cnt_next = window_inc;
                            publish_next    = 1'b0;
                        end
                    end
                    else
                    begin
                        sample_cnt_next = sample_inc;
                        stats_next      = 1'b0;
                        publish_next    = 1'b0;
                        state_next      = ST_DONE;
                    end
                end
            end
            ST_WALK:
            begin
                prod_next = mul_out;
                acc_next  = acc_reg + prod_reg[SQ_W-1:0];
                if (step_reg < STEP_W'(STATS_WINDOW))
                begin
                    if (rd_data > run_hi_reg)
                    begin
                        run_hi_next = rd_data;
                    end
                    if (rd_data < run_lo_reg)
                    begin
                        run_lo_next = rd_data;
                    end
                    step_next = step_reg + 1'b1;
                end
                else
                begin
                    if (publish_reg)
                    begin
                        held_hi_next = run_hi_reg;
                        held_lo_next = run_lo_reg;
                        run_hi_next  = '0;
                        run_lo_next  = VALUE_W'(FULL_SCALE);
                    end
                    state_next = ST_RECIP;
                end
            end
            ST_RECIP:
            begin
                prod_next  = mul_out;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                rem_next   = SQ_BIT_W'(prod_reg[RECIP_SHIFT +: MEAN_W]);
                root_next  = '0;
                bit_next   = SQ_BIT_W'(1) << SQ_TOP;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (trial_ok)
                begin
                    rem_next  = rem_reg - trial[SQ_BIT_W-1:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    rms_next   = root_next[VALUE_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sample_cnt_reg <= '0;
            window_cnt_reg <= '0;
            stats_reg      <= 1'b0;
            publish_reg    <= 1'b0;
            run_hi_reg     <= '0;
            run_lo_reg     <= VALUE_W'(FULL_SCALE);
            held_hi_reg    <= '0;
            held_lo_reg    <= '0;
            rms_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sample_cnt_reg <= sample_cnt_next;
            window_cnt_reg <= window_cnt_next;
            stats_reg      <= stats_next;
            publish_reg    <= publish_next;
            run_hi_reg     <= run_hi_next;
            run_lo_reg     <= run_lo_next;
            held_hi_reg    <= held_hi_next;
            held_lo_reg    <= held_lo_next;
            rms_reg        <= rms_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign rd_idx        = step_reg[WIN_IDX_W-1:0];
    assign idle          = (state_reg == ST_IDLE);
    assign done          = (state_reg == ST_DONE);
    assign res.stats     = stats_reg;
    assign res.publish   = publish_reg;
    assign res.rms       = rms_reg;
    assign res.held_high = held_hi_reg;
    assign res.held_low  = held_lo_reg;

endmodule

// ===== hdl/boxcar_filter_rms_min_max.sv =====
// top level: config registers, output register and handshakes around the window and stats units
// depends on bfrmm_pkg, bfrmm_window, bfrmm_stats
//
// channel   signals                              transfer when
// in        in_valid, in_stall, adc_sample       in_valid & !in_stall
// out       out_valid, out_stall, six results    out_valid & !out_stall
// cfg       cfg_we, cfg_index, cfg_data          cfg_we
//
// a sample with no stats update goes from the idle state through the done state to the output register
// a stats update adds a walk of the 10-entry window through the shared multiplier,
// one reciprocal multiply and load, and a 14-step square root
// in_stall stays high from a transfer until the result moves into the output register
// a full output register holding under out_stall keeps the core in its done state
// reset clears both delay lines, counters and extremes; no clearing pass
module boxcar_filter_rms_min_max (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [9:0]                          adc_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [13:0]                         filtered_value,
    output logic [13:0]                         rms_level,
    output logic [13:0]                         published_max,
    output logic [13:0]                         published_min,
    output logic                                stats_updated,
    output logic                                extremes_published,
    input  logic                                cfg_we,
    input  logic [bfrmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfrmm_pkg::CFG_W-1:0]         cfg_data
);
    import bfrmm_pkg::*;

    logic [CFG_W-1:0]     stats_interval_reg;
    logic [CFG_W-1:0]     publish_interval_reg;
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 take;
    logic                 core_idle;
    logic                 core_done;
    win_ctrl_t            win_ctrl;
    logic [WIN_IDX_W-1:0] rd_idx;
    logic [VALUE_W-1:0]   rd_data;
    logic [VALUE_W-1:0]   win_sum;
    stats_res_t           core_res;

    logic                 out_valid_reg;
    logic [VALUE_W-1:0]   filtered_reg;
    stats_res_t           res_reg;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign in_stall = !core_idle;
    assign take     = core_done && (!out_valid_reg || !out_stall);

    assign win_ctrl.shift  = in_xfer;
    assign win_ctrl.rd_idx = rd_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_interval_reg   <= STATS_INTERVAL_RST;
            publish_interval_reg <= PUBLISH_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STATS_INTERVAL:   stats_interval_reg   <= cfg_data;
                CFG_PUBLISH_INTERVAL: publish_interval_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    bfrmm_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (win_ctrl),
        .sample  (adc_sample[SAMPLE_BITS-1:0]),
        .sum     (win_sum),
        .rd_data (rd_data)
    );

    bfrmm_stats u_stats (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (in_xfer),
        .take             (take),
        .stats_interval   (stats_interval_reg),
        .publish_interval (publish_interval_reg),
        .rd_data          (rd_data),
        .rd_idx           (rd_idx),
        .idle             (core_idle),
        .done             (core_done),
        .res              (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            filtered_reg <= win_sum;
            res_reg      <= core_res;
        end
    end

    assign out_valid          = out_valid_reg;
    assign filtered_value     = filtered_reg;
    assign rms_level          = res_reg.rms;
    assign published_max      = res_reg.held_high;
    assign published_min      = res_reg.held_low;
    assign stats_updated      = res_reg.stats;
    assign extremes_published = res_reg.publish;

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_stall
    ) else $error("core took a sample without going busy");

    a_publish_needs_stats: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (!extremes_published || stats_updated)
    ) else $error("publish flagged without a stats update");

    a_published_order: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && extremes_published) |-> (published_max >= published_min)
    ) else $error("published max below published min");

    a_take_loads_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        take |=> (out_valid && core_idle)
    ) else $error("result handoff did not load the output register");

endmodule
